// ===== hw/rtl/mdp_pkg.sv =====
// mdp_pkg: shared constants, types and state codes for the minimum pairwise
// distance block
// no dependencies
package mdp_pkg;

  // capacity of the point ring
  localparam int MAX_POINTS = 64;
  localparam int COORD_W    = 17;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int ROOT_W     = SQ_W / 2;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int STEP_W     = $clog2(ROOT_W + 1);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [SQ_W-1:0]    square_t;
  typedef logic [ROOT_W-1:0]  root_t;

  localparam square_t SQ_ALL_ONES = '1;

  // one squared distance leaving the distance pipeline
  typedef struct packed {
    logic    valid;
    square_t square;
  } dist_res_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INSERT,
    ST_DRAIN,
    ST_ROOT,
    ST_EMIT
  } state_t;

endpackage

// ===== hw/rtl/mdp_cell.sv =====
// mdp_cell: one cell of the point ring, holds one stored point and passes it
// to its neighbor on every shift
// depends on mdp_pkg
module mdp_cell
  import mdp_pkg::*;
(
  input  logic   clk,
  input  logic   shift_en,
  input  coord_t x_in,
  input  coord_t y_in,
  output coord_t x_out,
  output coord_t y_out
);

  coord_t x_hold;
  coord_t y_hold;

  // point register, payload only
  always_ff @(posedge clk) begin
    if (shift_en) begin
      x_hold <= x_in;
      y_hold <= y_in;
    end
  end

  assign x_out = x_hold;
  assign y_out = y_hold;

endmodule

// ===== hw/rtl/mdp_dist.sv =====
// mdp_dist: three-stage squared euclidean distance unit with saturation to
// the square width
// depends on mdp_pkg
module mdp_dist
  import mdp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  coord_t    ax,
  input  coord_t    ay,
  input  coord_t    bx,
  input  coord_t    by,
  output dist_res_t res,
  output logic      busy
);

  logic              v1;
  logic              v2;
  logic              res_valid;
  coord_t            dx;
  coord_t            dy;
  square_t           sqx;
  square_t           sqy;
  square_t           sqx_c;
  square_t           sqy_c;
  logic [SQ_W:0]     sum_c;
  square_t           sat_c;
  square_t           res_square;

  // products of the registered differences
  assign sqx_c = dx * dx;
  assign sqy_c = dy * dy;

  // sum and clamp to all ones
  assign sum_c = {1'b0, sqx} + {1'b0, sqy};
  assign sat_c = sum_c[SQ_W] ? SQ_ALL_ONES : sum_c[SQ_W-1:0];

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v1        <= req_valid;
      v2        <= v1;
      res_valid <= v2;
    end
  end

  // data pipeline
  always_ff @(posedge clk) begin
    dx         <= (ax > bx) ? (ax - bx) : (bx - ax);
    dy         <= (ay > by) ? (ay - by) : (by - ay);
    sqx        <= sqx_c;
    sqy        <= sqy_c;
    res_square <= sat_c;
  end

  assign res  = '{valid: res_valid, square: res_square};
  assign busy = v1 | v2 | res_valid;

endmodule

// ===== hw/rtl/mdp_isqrt.sv =====
// mdp_isqrt: bit-serial floor square root, one result bit per cycle
// depends on mdp_pkg
module mdp_isqrt
  import mdp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  square_t value,
  output root_t   root,
  output logic    done
);

  localparam int REM_W = ROOT_W + 2;

  logic [STEP_W-1:0] steps_left;
  logic [REM_W-1:0]  rem;
  square_t           operand;
  logic [REM_W+1:0]  rem_try;
  logic [REM_W+1:0]  trial;
  logic              fits;

  // next two bits of the operand against the trial subtrahend
  assign rem_try = {rem, operand[SQ_W-1 -: 2]};
  assign trial   = {2'b00, root, 2'b01};
  assign fits    = rem_try >= trial;

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        steps_left <= STEP_W'(ROOT_W);
      end else if (steps_left != '0) begin
        steps_left <= steps_left - 1'b1;
        if (steps_left == STEP_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // remainder, root and operand registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      root    <= '0;
      operand <= value;
    end else if (steps_left != '0) begin
      rem     <= fits ? REM_W'(rem_try - trial) : REM_W'(rem_try);
      root    <= {root[ROOT_W-2:0], fits};
      operand <= {operand[SQ_W-3:0], 2'b00};
    end
  end

endmodule

// ===== hw/rtl/min_pairwise_distance_2d.sv =====
// Minimum pairwise distance of a set of 2D points. Each accepted point that
// fits is compared with every stored point and the smallest squared distance
// is kept; the point marked last_point closes the set and yields one result,
// the floor square root of that minimum, with no_pair set when fewer than two
// points were stored and overflow set when points past the 64-point capacity
// were dropped. Stored points sit in a ring of 64 cells that rotates once
// around per point, past one shared three-stage distance unit; each point runs
// through the ring rotation, the insert step and the pipeline drain, while a
// dropped point goes straight to the drain. The last point adds the bit-serial
// square root (skipped with under two stored points) and the result load. A new
// point is taken while an earlier result still waits in the output register.
// depends on mdp_pkg, mdp_cell, mdp_dist, mdp_isqrt
module min_pairwise_distance_2d
  import mdp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  coord_t x_coord,
  input  coord_t y_coord,
  input  logic   last_point,
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t min_distance,
  output logic   no_pair,
  output logic   overflow
);

  state_t            state;
  state_t            state_next;
  logic              accept;
  logic [CNT_W-1:0]  point_count;
  square_t           best_square;
  logic              dropped_flag;
  coord_t            cur_x;
  coord_t            cur_y;
  logic              cur_last;
  logic [IDX_W-1:0]  scan_step;
  logic [CNT_W-1:0]  scan_orig;
  logic              ring_shift;
  logic              ring_insert;
  logic              cmp_issue;
  logic              root_start;
  logic              out_load;
  logic              pipe_busy;
  logic              root_done;
  root_t             root_val;
  dist_res_t         dist_res;
  coord_t            cell_x [MAX_POINTS];
  coord_t            cell_y [MAX_POINTS];
  coord_t            head_x;
  coord_t            head_y;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid & in_ready;

  // original slot of the point now at the ring tail
  assign scan_orig = CNT_W'(MAX_POINTS - 1) - {1'b0, scan_step};

  // ring of stored points, head takes the tail or the new point
  assign head_x = ring_insert ? cur_x : cell_x[MAX_POINTS-1];
  assign head_y = ring_insert ? cur_y : cell_y[MAX_POINTS-1];

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_ring
    if (i == 0) begin : g_head
      mdp_cell u_cell (
        .clk      (clk),
        .shift_en (ring_shift),
        .x_in     (head_x),
        .y_in     (head_y),
        .x_out    (cell_x[i]),
        .y_out    (cell_y[i])
      );
    end else begin : g_body
      mdp_cell u_cell (
        .clk      (clk),
        .shift_en (ring_shift),
        .x_in     (cell_x[i-1]),
        .y_in     (cell_y[i-1]),
        .x_out    (cell_x[i]),
        .y_out    (cell_y[i])
      );
    end
  end

  // shared distance unit at the ring tail
  mdp_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .req_valid (cmp_issue),
    .ax        (cur_x),
    .ay        (cur_y),
    .bx        (cell_x[MAX_POINTS-1]),
    .by        (cell_y[MAX_POINTS-1]),
    .res       (dist_res),
    .busy      (pipe_busy)
  );

  // square root of the minimum
  mdp_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value (best_square),
    .root  (root_val),
    .done  (root_done)
  );

  // next state and sequencer controls
  always_comb begin
    state_next  = state;
    ring_shift  = 1'b0;
    ring_insert = 1'b0;
    cmp_issue   = 1'b0;
    root_start  = 1'b0;
    out_load    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (point_count == CNT_W'(MAX_POINTS)) ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        ring_shift = 1'b1;
        cmp_issue  = scan_orig < point_count;
        if (scan_step == IDX_W'(MAX_POINTS - 1)) begin
          state_next = ST_INSERT;
        end
      end
      ST_INSERT: begin
        ring_shift  = 1'b1;
        ring_insert = 1'b1;
        state_next  = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          if (!cur_last) begin
            state_next = ST_IDLE;
          end else if (point_count < CNT_W'(2)) begin
            state_next = ST_EMIT;
          end else begin
            root_start = 1'b1;
            state_next = ST_ROOT;
          end
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // set state: count, running minimum, drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count  <= '0;
      best_square  <= SQ_ALL_ONES;
      dropped_flag <= 1'b0;
    end else if (out_load) begin
      point_count  <= '0;
      best_square  <= SQ_ALL_ONES;
      dropped_flag <= 1'b0;
    end else begin
      if (accept && point_count == CNT_W'(MAX_POINTS)) begin
        dropped_flag <= 1'b1;
      end
      if (ring_insert) begin
        point_count <= point_count + 1'b1;
      end
      if (dist_res.valid && dist_res.square < best_square) begin
        best_square <= dist_res.square;
      end
    end
  end

  // current request and rotation step
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x     <= x_coord;
      cur_y     <= y_coord;
      cur_last  <= last_point;
      scan_step <= '0;
    end else if (state == ST_SCAN) begin
      scan_step <= scan_step + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      min_distance <= (point_count < CNT_W'(2)) ? '0 : coord_t'(root_val);
      no_pair      <= point_count < CNT_W'(2);
      overflow     <= dropped_flag;
    end
  end

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    point_count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_dist_in_work: assert property (@(posedge clk) disable iff (rst)
    dist_res.valid |-> (state == ST_SCAN || state == ST_INSERT || state == ST_DRAIN))
    else $error("distance result outside of a point's work");

  a_root_done_state: assert property (@(posedge clk) disable iff (rst)
    root_done |-> state == ST_ROOT)
    else $error("square root finished outside of the root state");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted request did not start work");

  a_root_quiet_pipe: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROOT |-> !pipe_busy)
    else $error("distance pipeline busy during square root");
`endif

endmodule

// ===== bench/tb_min_pairwise_distance_2d.sv =====
// tb_min_pairwise_distance_2d: self-checking bench for the minimum pairwise
// distance block, with a scoreboard class that predicts one result per closed set
// depends on mdp_pkg and min_pairwise_distance_2d
module tb_min_pairwise_distance_2d
  import mdp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    coord_t min_distance;
    logic   no_pair;
    logic   overflow;
  } pair_result_t;

  // tracks the current point set and the results owed for closed sets
  class closest_pair_board;
    coord_t       pts_x [MAX_POINTS];
    coord_t       pts_y [MAX_POINTS];
    int unsigned  held;
    square_t      best_sq;
    bit           dropped;
    pair_result_t closed_sets [$];
    int unsigned  faults;
    int unsigned  points_taken;
    int unsigned  sets_seen;
    int unsigned  sets_single;
    int unsigned  sets_dropped;

    function new();
      clear_set();
      faults       = 0;
      points_taken = 0;
      sets_seen    = 0;
      sets_single  = 0;
      sets_dropped = 0;
    endfunction

    function void clear_set();
      held    = 0;
      best_sq = SQ_ALL_ONES;
      dropped = 1'b0;
    endfunction

    // squared euclidean distance, saturated to the 34-bit range
    function square_t span_square(coord_t ax, coord_t ay, coord_t bx, coord_t by);
      logic [COORD_W-1:0] dx;
      logic [COORD_W-1:0] dy;
      logic [SQ_W+1:0]    sum;
      dx  = (ax > bx) ? ax - bx : bx - ax;
      dy  = (ay > by) ? ay - by : by - ay;
      sum = dx * dx + dy * dy;
      return (sum > {2'b00, SQ_ALL_ONES}) ? SQ_ALL_ONES : sum[SQ_W-1:0];
    endfunction

    // floor integer square root, digit by digit
    function coord_t floor_root(square_t v);
      longint unsigned rem;
      longint unsigned root;
      longint unsigned probe;
      rem   = v;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > rem) probe >>= 2;
      while (probe != 0) begin
        if (rem >= root + probe) begin
          rem  -= root + probe;
          root  = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      return coord_t'(root);
    endfunction

    // accepted point request: compare, store or drop, close the set on last
    function void take_point(coord_t x, coord_t y, logic last);
      square_t      d;
      pair_result_t r;
      points_taken++;
      if (held < MAX_POINTS) begin
        for (int i = 0; i < held; i++) begin
          d = span_square(x, y, pts_x[i], pts_y[i]);
          if (d < best_sq) best_sq = d;
        end
        pts_x[held] = x;
        pts_y[held] = y;
        held++;
      end else begin
        dropped = 1'b1;
      end
      if (last) begin
        r.no_pair      = (held < 2);
        r.min_distance = r.no_pair ? '0 : floor_root(best_sq);
        r.overflow     = dropped;
        closed_sets.push_back(r);
        sets_seen++;
        if (r.no_pair) sets_single++;
        if (r.overflow) sets_dropped++;
        clear_set();
      end
    endfunction

    // accepted result: compare with the oldest closed set
    function void check_result(coord_t md, logic np, logic ov);
      pair_result_t want;
      if (closed_sets.size() == 0) begin
        $error("result with no closed set pending: min_distance %0d no_pair %0b overflow %0b",
               md, np, ov);
        faults++;
        return;
      end
      want = closed_sets.pop_front();
      if (md !== want.min_distance) begin
        $error("min_distance expected %0d actual %0d", want.min_distance, md);
        faults++;
      end
      if (np !== want.no_pair) begin
        $error("no_pair expected %0b actual %0b", want.no_pair, np);
        faults++;
      end
      if (ov !== want.overflow) begin
        $error("overflow expected %0b actual %0b", want.overflow, ov);
        faults++;
      end
    endfunction
  endclass

  logic   clk;
  logic   rst;
  logic   in_valid;
  logic   in_ready;
  coord_t x_coord;
  coord_t y_coord;
  logic   last_point;
  logic   out_valid;
  logic   out_ready;
  coord_t min_distance;
  logic   no_pair;
  logic   overflow;

  closest_pair_board board = new();
  bit     calm = 1'b0;
  coord_t prev_x = '0;
  coord_t prev_y = '0;

  min_pairwise_distance_2d u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .last_point   (last_point),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .min_distance (min_distance),
    .no_pair      (no_pair),
    .overflow     (overflow)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

  // present one point request and hold it until accepted
  task automatic send_point(input coord_t x, input coord_t y, input logic last);
    in_valid   <= 1'b1;
    x_coord    <= x;
    y_coord    <= y;
    last_point <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_point(x, y, last);
  endtask

  // random point: half in range, some near the previous one, some at edge values, some raw 17-bit
  function automatic void pick_point(output coord_t px, output coord_t py);
    int mode;
    int t;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      px = coord_t'($urandom);
      py = coord_t'($urandom);
    end else if (mode == 1) begin
      case ($urandom_range(0, 2))
        0: px = 17'd0;
        1: px = 17'd65536;
        default: px = 17'h1FFFF;
      endcase
      case ($urandom_range(0, 2))
        0: py = 17'd0;
        1: py = 17'd65536;
        default: py = 17'h1FFFF;
      endcase
    end else if (mode <= 4) begin
      t  = int'(prev_x) + int'($urandom_range(0, 64)) - 32;
      px = (t < 0) ? 17'd0 : (t > 131071) ? 17'h1FFFF : coord_t'(t);
      t  = int'(prev_y) + int'($urandom_range(0, 64)) - 32;
      py = (t < 0) ? 17'd0 : (t > 131071) ? 17'h1FFFF : coord_t'(t);
    end else begin
      px = coord_t'($urandom_range(0, 65536));
      py = coord_t'($urandom_range(0, 65536));
    end
    prev_x = px;
    prev_y = py;
  endfunction

  // result side: ready with random stall bursts until the calm tail
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(min_distance, no_pair, overflow);
  end

  // reset, directed sets, random sets, drain
  initial begin
    int     sent;
    int     size;
    int     forced;
    coord_t px;
    coord_t py;
    sent   = 0;
    forced = 0;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    x_coord    <= '0;
    y_coord    <= '0;
    last_point <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-point sets give no pair
    send_point(17'd0, 17'd0, 1'b1);
    send_point(17'd65536, 17'd65536, 1'b1);
    // opposite corners of the unit square
    send_point(17'd0, 17'd0, 1'b0);
    send_point(17'd65536, 17'd65536, 1'b1);
    // identical points
    send_point(17'd12345, 17'd54321, 1'b0);
    send_point(17'd12345, 17'd54321, 1'b1);
    // coordinates above 1.0, squared distance saturates
    send_point(17'h1FFFF, 17'h1FFFF, 1'b0);
    send_point(17'd0, 17'd0, 1'b1);
    // largest distance along one axis, just below saturation
    send_point(17'h1FFFF, 17'd0, 1'b0);
    send_point(17'd0, 17'd0, 1'b1);
    // minimum set by an earlier pair
    send_point(17'd100, 17'd100, 1'b0);
    send_point(17'd103, 17'd104, 1'b0);
    send_point(17'd60000, 17'd60000, 1'b1);
    // diagonal neighbors
    send_point(17'd0, 17'd65536, 1'b0);
    send_point(17'd65536, 17'd0, 1'b0);
    send_point(17'd1, 17'd65535, 1'b1);
    // unit step on one axis
    send_point(17'd65535, 17'd0, 1'b0);
    send_point(17'd65536, 17'd0, 1'b1);
    // alternating bit patterns
    send_point(17'h15555, 17'h0AAAA, 1'b0);
    send_point(17'h0AAAA, 17'h15555, 1'b1);

    // random sets; the first three sit at the capacity edge
    while (sent < 700) begin
      if (forced < 3) begin
        size = (forced == 0) ? 66 : (forced == 1) ? MAX_POINTS : MAX_POINTS + 1;
        forced++;
      end else if ($urandom_range(0, 19) == 0) begin
        size = $urandom_range(60, 70);
      end else begin
        size = $urandom_range(1, 8);
      end
      for (int k = 0; k < size; k++) begin
        pick_point(px, py);
        if (sent >= 600) calm = 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        send_point(px, py, k == size - 1);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // wait for every owed result, then let the pipeline settle
    while (board.closed_sets.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("covered %0d point requests in %0d sets: %0d without a pair, %0d past capacity",
             board.points_taken, board.sets_seen, board.sets_single, board.sets_dropped);
    if (board.faults == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
